[hw/rtl/bpmc_pkg.sv]
// Shared types, command codes and arithmetic helpers for the balance controller.
// No dependencies; imported by bpmc_ctrl, bpmc_datapath and the top level.
package bpmc_pkg;

    // Arctangent iterations and the width of their counter
    localparam int ATAN_STEPS = 16;
    localparam int ITER_W     = $clog2(ATAN_STEPS);

    // Datapath operations issued by the sequencer
    typedef logic [4:0] op_t;
    localparam op_t OP_NONE   = 5'd0;
    localparam op_t OP_REMOTE = 5'd1;
    localparam op_t OP_LOAD   = 5'd2;
    localparam op_t OP_CORDIC = 5'd3;
    localparam op_t OP_ACC    = 5'd4;
    localparam op_t OP_MUL_BA = 5'd5;
    localparam op_t OP_MUL_BP = 5'd6;
    localparam op_t OP_FUSE   = 5'd7;
    localparam op_t OP_ANGLE  = 5'd8;
    localparam op_t OP_MUL_KP = 5'd9;
    localparam op_t OP_MUL_KD = 5'd10;
    localparam op_t OP_MUL_KI = 5'd11;
    localparam op_t OP_INTEG  = 5'd12;
    localparam op_t OP_BAL    = 5'd13;
    localparam op_t OP_MIX    = 5'd14;
    localparam op_t OP_MOTOR  = 5'd15;
    localparam op_t OP_EMIT   = 5'd16;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_PROP  = 3'd0;
    localparam logic [2:0] CFG_INTEG = 3'd1;
    localparam logic [2:0] CFG_DERIV = 3'd2;
    localparam logic [2:0] CFG_BLEND = 3'd3;
    localparam logic [2:0] CFG_ORATE = 3'd4;
    localparam logic [2:0] CFG_FLOOR = 3'd5;
    localparam logic [2:0] CFG_SLEW  = 3'd6;
    localparam logic [2:0] CFG_DLIM  = 3'd7;

    // Remote command bytes
    localparam logic [7:0] RC_FWD        = 8'd1;
    localparam logic [7:0] RC_STOP_A     = 8'd2;
    localparam logic [7:0] RC_REV        = 8'd3;
    localparam logic [7:0] RC_STOP_B     = 8'd4;
    localparam logic [7:0] RC_TURN_POS   = 8'd5;
    localparam logic [7:0] RC_TURN_OFF_A = 8'd6;
    localparam logic [7:0] RC_TURN_NEG   = 8'd7;
    localparam logic [7:0] RC_TURN_OFF_B = 8'd8;

    // Arctangent of 2^-i in Q.28 degrees
    function automatic logic signed [36:0] atan_entry(input logic [ITER_W-1:0] i);
        logic signed [36:0] r;
        case (i)
            4'd0:    r = 37'sd12079595520;
            4'd1:    r = 37'sd7131001626;
            4'd2:    r = 37'sd3767825416;
            4'd3:    r = 37'sd1912607013;
            4'd4:    r = 37'sd960014949;
            4'd5:    r = 37'sd480475470;
            4'd6:    r = 37'sd240296363;
            4'd7:    r = 37'sd120155514;
            4'd8:    r = 37'sd60078674;
            4'd9:    r = 37'sd30039451;
            4'd10:   r = 37'sd15019740;
            4'd11:   r = 37'sd7509872;
            4'd12:   r = 37'sd3754936;
            4'd13:   r = 37'sd1877468;
            4'd14:   r = 37'sd938734;
            4'd15:   r = 37'sd469367;
            default: r = 37'sd0;
        endcase
        return r;
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        if (v[55:31] == '0 || v[55:31] == '1) begin
            r = v[31:0];
        end else if (v[55]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    // Truncating divide by 10*2^16, then clamp to +-127
    function automatic logic signed [7:0] motor_div(input logic signed [28:0] v);
        logic [27:0] mag;
        logic [11:0] n;
        logic [24:0] prod;
        logic [8:0]  q;
        logic [7:0]  qc;
        mag  = v[28] ? 28'(-v) : 28'(v);
        n    = mag[27:16];
        prod = 25'(n) * 25'd6554;
        q    = prod[24:16];
        qc   = (q > 9'd127) ? 8'd127 : q[7:0];
        return v[28] ? -signed'(qc) : signed'(qc);
    endfunction

    // Limit the change of a motor command against its previous value
    function automatic logic signed [7:0] slew_limit(input logic signed [7:0] s,
                                                     input logic signed [7:0] prev,
                                                     input logic [6:0] step);
        logic signed [9:0] diff;
        logic signed [9:0] stp;
        logic signed [9:0] r;
        diff = 10'(s) - 10'(prev);
        stp  = signed'({3'b0, step});
        if (diff > stp) begin
            r = 10'(prev) + stp;
        end else if (diff < -stp) begin
            r = 10'(prev) - stp;
        end else begin
            r = 10'(s);
        end
        return r[7:0];
    endfunction

endpackage

[hw/rtl/bpmc_ctrl.sv]
// Sequencer for the balance controller: steps the datapath through one tick or a remote byte.
// Depends on bpmc_pkg for the command struct and operation codes.
module bpmc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_cmd,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output bpmc_pkg::dp_cmd_t dp_cmd
);
    import bpmc_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CORD = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_MBA  = 4'd3;
    localparam logic [3:0] ST_MBP  = 4'd4;
    localparam logic [3:0] ST_FUSE = 4'd5;
    localparam logic [3:0] ST_ANG  = 4'd6;
    localparam logic [3:0] ST_MKP  = 4'd7;
    localparam logic [3:0] ST_MKD  = 4'd8;
    localparam logic [3:0] ST_MKI  = 4'd9;
    localparam logic [3:0] ST_INTG = 4'd10;
    localparam logic [3:0] ST_BAL  = 4'd11;
    localparam logic [3:0] ST_MIX  = 4'd12;
    localparam logic [3:0] ST_MOT  = 4'd13;
    localparam logic [3:0] ST_DONE = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              mvalid_reg, mvalid_next;
    op_t               op;

    // Next state and command decode
    always_comb begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        mvalid_next = mvalid_reg && !m_ready;
        op          = OP_NONE;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd) begin
                        op = OP_REMOTE;
                    end else begin
                        op         = OP_LOAD;
                        iter_next  = '0;
                        state_next = ST_CORD;
                    end
                end
            end
            ST_CORD: begin
                op        = OP_CORDIC;
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(ATAN_STEPS - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:  begin op = OP_ACC;    state_next = ST_MBA;  end
            ST_MBA:  begin op = OP_MUL_BA; state_next = ST_MBP;  end
            ST_MBP:  begin op = OP_MUL_BP; state_next = ST_FUSE; end
            ST_FUSE: begin op = OP_FUSE;   state_next = ST_ANG;  end
            ST_ANG:  begin op = OP_ANGLE;  state_next = ST_MKP;  end
            ST_MKP:  begin op = OP_MUL_KP; state_next = ST_MKD;  end
            ST_MKD:  begin op = OP_MUL_KD; state_next = ST_MKI;  end
            ST_MKI:  begin op = OP_MUL_KI; state_next = ST_INTG; end
            ST_INTG: begin op = OP_INTEG;  state_next = ST_BAL;  end
            ST_BAL:  begin op = OP_BAL;    state_next = ST_MIX;  end
            ST_MIX:  begin op = OP_MIX;    state_next = ST_MOT;  end
            ST_MOT:  begin op = OP_MOTOR;  state_next = ST_DONE; end
            ST_DONE: begin
                // hold until the output register is free
                if (!mvalid_reg || m_ready) begin
                    op          = OP_EMIT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            iter_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            iter_reg   <= iter_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign m_valid     = mvalid_reg;
    assign dp_cmd.op   = op;
    assign dp_cmd.iter = iter_reg;

endmodule

[hw/rtl/bpmc_datapath.sv]
// Datapath of the balance controller: CORDIC, shared multiplier, filter, PID, motors.
// Depends on bpmc_pkg; bpmc_ctrl drives one op per cycle unless idle or stalled.
module bpmc_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpmc_pkg::dp_cmd_t dp_cmd,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic signed [7:0] s_accel_x,
    input  logic signed [7:0] s_accel_z,
    input  logic signed [7:0] s_gyro_y,
    input  logic [9:0]        s_adc_sample,
    input  logic [15:0]       s_throttle_capture,
    input  logic [15:0]       s_steer_start,
    input  logic [15:0]       s_steer_end,
    input  logic [7:0]        s_remote_byte,
    output logic [11:0]       m_left_compare,
    output logic [11:0]       m_right_compare,
    output logic [11:0]       m_servo_compare,
    output logic [7:0]        m_battery_byte,
    output logic              m_motors_written,
    output logic              m_tilt_ok
);
    import bpmc_pkg::*;

    // Configuration
    logic [15:0] kp_reg, ki_reg, kd_reg, blend_reg, orate_reg;
    logic [7:0]  floor_reg;
    logic [6:0]  slew_reg, dlim_reg;

    // Latched tick inputs
    logic signed [7:0] ax_reg, az_reg, gyro_reg;
    logic [7:0]        batt_reg;
    logic [15:0]       thr_reg, ss_reg, se_reg;

    // Working registers
    logic signed [34:0] cx_reg, cy_reg;
    logic signed [36:0] cz_reg;
    logic signed [24:0] acc_reg;
    logic signed [31:0] pre_reg, angle_reg;
    logic signed [32:0] err_reg, dlt_reg;
    logic signed [51:0] p_reg, sum_reg;
    logic signed [40:0] pd_reg;
    logic signed [23:0] bal_reg;
    logic signed [7:0]  m1_reg, m2_reg;
    logic               tilt_reg, written_reg;
    logic [11:0]        servo_reg;

    // Controller state
    logic signed [31:0] fused_reg, prev_reg, zo_reg;
    logic signed [23:0] integ_reg;
    logic signed [7:0]  gs_reg, lprev_reg, rprev_reg;
    logic signed [1:0]  dir_reg;
    logic signed [4:0]  turn_reg;
    logic [7:0]         lr_reg;
    logic [11:0]        lhold_reg, rhold_reg;

    // Output register
    logic [11:0] out_left_reg, out_right_reg, out_servo_reg;
    logic [7:0]  out_batt_reg;
    logic        out_written_reg, out_tilt_reg;

    localparam logic signed [55:0] INT_LIM  = 56'sd8323072;
    localparam logic signed [24:0] NINETY   = 25'sd5898240;
    localparam logic signed [24:0] FORTY    = 25'sd2621440;
    localparam logic signed [31:0] ZO_LIM   = 32'sd5898240;

    // Combinational helpers
    logic [8:0]         axa;
    logic signed [8:0]  azn;
    logic signed [34:0] dx, dy;
    logic signed [36:0] tab;
    logic signed [24:0] acc_w;
    logic [7:0]         gmag;
    logic [19:0]        rq;
    logic [27:0]        rfrac;
    logic signed [20:0] rate_w;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [55:0] fsum, psum, isum, zsum;
    logic signed [31:0] angle_w;
    logic signed [1:0]  dir_w;
    logic signed [4:0]  turn_w;
    logic signed [16:0] width_w, pulse_w;
    logic signed [7:0]  gs_w;
    logic signed [41:0] bsum, blim;
    logic signed [23:0] abal;
    logic signed [28:0] vbase, vturn;
    logic signed [7:0]  s1_w, s2_w, t1_w, t2_w;
    logic signed [8:0]  o1_w, o2_w;
    logic signed [55:0] step_w;
    logic signed [37:0] snum, sdiv;
    logic signed [22:0] sv_w;
    logic [11:0]        servo_w;

    always_comb begin
        // arctangent setup and one rotation
        axa   = s_accel_x[7] ? 9'(-(9'(s_accel_x))) : 9'(s_accel_x);
        azn   = s_accel_x[7] ? -(9'(s_accel_z)) : 9'(s_accel_z);
        dx    = cy_reg >>> dp_cmd.iter;
        dy    = cx_reg >>> dp_cmd.iter;
        tab   = atan_entry(dp_cmd.iter);
        if (ax_reg == 8'sd0) begin
            acc_w = az_reg[7] ? -NINETY : NINETY;
        end else begin
            acc_w = 25'((cz_reg + 37'sd2048) >>> 12);
        end

        // gyro rate = g * 2^16 / 21, truncated toward zero
        gmag   = gyro_reg[7] ? 8'(-(9'(gyro_reg))) : 8'(gyro_reg);
        rfrac  = 28'(gmag) * 28'd49936;
        rq     = 20'(gmag) * 20'd3120 + 20'(rfrac[27:16]);
        rate_w = gyro_reg[7] ? -signed'({1'b0, rq}) : signed'({1'b0, rq});

        // shared multiplier operand select
        mul_a = '0;
        mul_b = '0;
        case (dp_cmd.op)
            OP_MUL_BA: begin mul_a = 34'(acc_reg); mul_b = signed'({2'b0, blend_reg}); end
            OP_MUL_BP: begin
                mul_a = 34'(pre_reg);
                mul_b = 18'sd65536 - signed'({2'b0, blend_reg});
            end
            OP_MUL_KP: begin mul_a = 34'(err_reg); mul_b = signed'({2'b0, kp_reg}); end
            OP_MUL_KD: begin mul_a = 34'(dlt_reg); mul_b = signed'({2'b0, kd_reg}); end
            OP_MUL_KI: begin mul_a = 34'(err_reg); mul_b = signed'({2'b0, ki_reg}); end
            OP_MIX:    begin mul_a = 34'(abal);    mul_b = signed'({2'b0, orate_reg}); end
            default: ;
        endcase
        mul_p = 52'(mul_a) * 52'(mul_b);

        // filter, angle and PID sums
        fsum    = (56'(sum_reg) + 56'(p_reg) + 56'sd32768) >>> 16;
        psum    = (56'(sum_reg) + 56'(p_reg) + 56'sd2048) >>> 12;
        isum    = ((56'(p_reg) + 56'sd2048) >>> 12) + 56'(integ_reg);
        angle_w = sat32(56'(fused_reg) + 56'(zo_reg));

        // drive direction from throttle, else from the last remote byte
        if (thr_reg > 16'd1600) begin
            dir_w = 2'sd1;
        end else if (thr_reg < 16'd1200 && thr_reg != 16'd0) begin
            dir_w = -2'sd1;
        end else if (lr_reg == 8'd0 || lr_reg == RC_STOP_A || lr_reg == RC_STOP_B) begin
            dir_w = 2'sd0;
        end else begin
            dir_w = dir_reg;
        end

        // turn from steering width, else from the last remote byte
        width_w = signed'({1'b0, se_reg}) - signed'({1'b0, ss_reg});
        if (width_w > 17'sd1600) begin
            turn_w = -5'sd8;
        end else if (width_w < 17'sd1200 && width_w != 17'sd0) begin
            turn_w = 5'sd8;
        end else if (lr_reg == 8'd0 || lr_reg == RC_TURN_OFF_A || lr_reg == RC_TURN_OFF_B) begin
            turn_w = 5'sd0;
        end else begin
            turn_w = turn_reg;
        end

        // ramp ground speed toward the direction
        gs_w = gs_reg;
        if (dir_w == 2'sd1) begin
            if (gs_reg > -8'sd100) gs_w = gs_reg - 8'sd1;
        end else if (dir_w == -2'sd1) begin
            if (gs_reg < 8'sd100) gs_w = gs_reg + 8'sd1;
        end else if (gs_reg > 8'sd0) begin
            gs_w = gs_reg - 8'sd1;
        end else if (gs_reg < 8'sd0) begin
            gs_w = gs_reg + 8'sd1;
        end

        // balance output
        bsum = 42'(pd_reg) + 42'(integ_reg);
        blim = signed'({19'b0, dlim_reg, 16'd0});
        abal = bal_reg[23] ? -bal_reg : bal_reg;

        // motor mix
        vbase = 29'(bal_reg) * 29'sd10 + (29'(gs_reg) <<< 16);
        vturn = 29'(turn_reg) * 29'sd655360;

        // slew and dead band
        t1_w = tilt_reg ? m1_reg : 8'sd0;
        t2_w = tilt_reg ? m2_reg : 8'sd0;
        s1_w = slew_limit(t1_w, lprev_reg, slew_reg);
        s2_w = slew_limit(t2_w, rprev_reg, slew_reg);
        o1_w = (s1_w > 8'sd0) ? 9'(s1_w) + 9'sd10 :
               (s1_w < 8'sd0) ? 9'(s1_w) - 9'sd10 : 9'sd0;
        o2_w = (s2_w > 8'sd0) ? 9'(s2_w) + 9'sd10 :
               (s2_w < 8'sd0) ? 9'(s2_w) - 9'sd10 : 9'sd0;

        // zero offset step
        step_w = (56'(p_reg) + 56'sd32768) >>> 16;
        if (angle_reg > 32'sd0) begin
            zsum = 56'(zo_reg) + step_w;
        end else begin
            zsum = 56'(zo_reg) - step_w;
        end

        // servo compare
        snum    = 38'sd93061120 + 38'(fused_reg) * 38'sd10;
        sdiv    = snum[37] ? ((snum + 38'sd65535) >>> 16) : (snum >>> 16);
        pulse_w = signed'({1'b0, ss_reg}) - signed'({1'b0, thr_reg});
        sv_w    = 23'(sdiv);
        if (pulse_w > 17'sd500 && pulse_w < 17'sd2500) begin
            sv_w = sv_w + 23'sd1420 - 23'(pulse_w);
        end
        if (sv_w < 23'sd720) begin
            servo_w = 12'd720;
        end else if (sv_w > 23'sd2120) begin
            servo_w = 12'd2120;
        end else begin
            servo_w = 12'(sv_w);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg    <= 16'd20480;
            ki_reg    <= 16'd328;
            kd_reg    <= 16'd20480;
            blend_reg <= 16'd655;
            orate_reg <= 16'd1638;
            floor_reg <= 8'd82;
            slew_reg  <= 7'd40;
            dlim_reg  <= 7'd110;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PROP:  kp_reg    <= cfg_data;
                CFG_INTEG: ki_reg    <= cfg_data;
                CFG_DERIV: kd_reg    <= cfg_data;
                CFG_BLEND: blend_reg <= cfg_data;
                CFG_ORATE: orate_reg <= cfg_data;
                CFG_FLOOR: floor_reg <= cfg_data[7:0];
                CFG_SLEW:  slew_reg  <= cfg_data[6:0];
                CFG_DLIM:  dlim_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Controller state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fused_reg <= '0;
            prev_reg  <= '0;
            zo_reg    <= '0;
            integ_reg <= '0;
            gs_reg    <= '0;
            dir_reg   <= '0;
            turn_reg  <= '0;
            lr_reg    <= '0;
            lprev_reg <= '0;
            rprev_reg <= '0;
            lhold_reg <= 12'd1500;
            rhold_reg <= 12'd1500;
        end else begin
            case (dp_cmd.op)
                OP_REMOTE: begin
                    lr_reg <= s_remote_byte;
                    case (s_remote_byte)
                        RC_FWD:        dir_reg  <= 2'sd1;
                        RC_STOP_A:     dir_reg  <= 2'sd0;
                        RC_STOP_B:     dir_reg  <= 2'sd0;
                        RC_REV:        dir_reg  <= -2'sd1;
                        RC_TURN_POS:   turn_reg <= 5'sd8;
                        RC_TURN_OFF_A: turn_reg <= 5'sd0;
                        RC_TURN_OFF_B: turn_reg <= 5'sd0;
                        RC_TURN_NEG:   turn_reg <= -5'sd8;
                        default: ;
                    endcase
                end
                OP_FUSE:  fused_reg <= sat32(fsum);
                OP_ANGLE: prev_reg  <= angle_w;
                OP_INTEG: begin
                    if (isum > INT_LIM) begin
                        integ_reg <= 24'(INT_LIM);
                    end else if (isum < -INT_LIM) begin
                        integ_reg <= 24'(-INT_LIM);
                    end else begin
                        integ_reg <= 24'(isum);
                    end
                    dir_reg  <= dir_w;
                    turn_reg <= turn_w;
                    gs_reg   <= gs_w;
                end
                OP_MOTOR: begin
                    if (batt_reg > floor_reg) begin
                        lprev_reg <= s1_w;
                        rprev_reg <= s2_w;
                        lhold_reg <= 12'(13'sd1500 - 13'(o1_w));
                        rhold_reg <= 12'(13'sd1509 + 13'(o2_w));
                    end
                    if ((angle_reg > 32'sd0 && zo_reg < ZO_LIM) ||
                        (angle_reg < 32'sd0 && zo_reg > -ZO_LIM)) begin
                        zo_reg <= sat32(zsum);
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge aclk) begin
        case (dp_cmd.op)
            OP_LOAD: begin
                ax_reg   <= s_accel_x;
                az_reg   <= s_accel_z;
                gyro_reg <= s_gyro_y;
                batt_reg <= s_adc_sample[9:2];
                thr_reg  <= s_throttle_capture;
                ss_reg   <= s_steer_start;
                se_reg   <= s_steer_end;
                cx_reg   <= signed'({2'b0, axa, 24'd0});
                cy_reg   <= {{2{azn[8]}}, azn, 24'd0};
                cz_reg   <= '0;
            end
            OP_CORDIC: begin
                if (cy_reg > 35'sd0) begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + tab;
                end else begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - tab;
                end
            end
            OP_ACC: begin
                acc_reg  <= acc_w;
                tilt_reg <= (acc_w < FORTY) && (acc_w > -FORTY);
                pre_reg  <= sat32(56'(fused_reg) + 56'(rate_w));
            end
            OP_MUL_BA: p_reg <= mul_p;
            OP_MUL_BP: begin sum_reg <= p_reg; p_reg <= mul_p; end
            OP_ANGLE: begin
                angle_reg <= angle_w;
                err_reg   <= -(33'(angle_w));
                dlt_reg   <= 33'(prev_reg) - 33'(angle_w);
            end
            OP_MUL_KP: p_reg <= mul_p;
            OP_MUL_KD: begin sum_reg <= p_reg; p_reg <= mul_p; end
            OP_MUL_KI: begin pd_reg <= 41'(psum); p_reg <= mul_p; end
            OP_BAL: begin
                if (bsum > blim) begin
                    bal_reg <= 24'(blim);
                end else if (bsum < -blim) begin
                    bal_reg <= 24'(-blim);
                end else begin
                    bal_reg <= 24'(bsum);
                end
            end
            OP_MIX: begin
                m1_reg <= motor_div(vbase + vturn);
                m2_reg <= motor_div(vbase - vturn);
                p_reg  <= mul_p;
            end
            OP_MOTOR: begin
                written_reg <= (batt_reg > floor_reg);
                servo_reg   <= servo_w;
            end
            OP_EMIT: begin
                out_left_reg    <= lhold_reg;
                out_right_reg   <= rhold_reg;
                out_servo_reg   <= servo_reg;
                out_batt_reg    <= batt_reg;
                out_written_reg <= written_reg;
                out_tilt_reg    <= tilt_reg;
            end
            default: ;
        endcase
    end

    assign m_left_compare   = out_left_reg;
    assign m_right_compare  = out_right_reg;
    assign m_servo_compare  = out_servo_reg;
    assign m_battery_byte   = out_batt_reg;
    assign m_motors_written = out_written_reg;
    assign m_tilt_ok        = out_tilt_reg;

endmodule

[hw/rtl/balance_pid_motor_controller.sv]
// Balance controller top level: sequencer plus datapath.
// A tick is accepted in idle; its result is registered after 16 arctangent rotations
// and six passes through the one shared multiplier; the next tick is taken back in idle.
// A remote byte is handled in idle and returns nothing. A pending result waits in an output
// register while the next item runs. Synchronous active-low reset restores the register
// defaults, clears the filter, PID and ramp state and sets both held compares to 1500.
module balance_pid_motor_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_cmd,
    input  logic signed [7:0] s_accel_x,
    input  logic signed [7:0] s_accel_z,
    input  logic signed [7:0] s_gyro_y,
    input  logic [9:0]        s_adc_sample,
    input  logic [15:0]       s_throttle_capture,
    input  logic [15:0]       s_steer_start,
    input  logic [15:0]       s_steer_end,
    input  logic [7:0]        s_remote_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [11:0]       m_left_compare,
    output logic [11:0]       m_right_compare,
    output logic [11:0]       m_servo_compare,
    output logic [7:0]        m_battery_byte,
    output logic              m_motors_written,
    output logic              m_tilt_ok,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import bpmc_pkg::*;

    dp_cmd_t dp_cmd;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    bpmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    bpmc_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .dp_cmd             (dp_cmd),
        .cfg_we             (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_accel_x          (s_accel_x),
        .s_accel_z          (s_accel_z),
        .s_gyro_y           (s_gyro_y),
        .s_adc_sample       (s_adc_sample),
        .s_throttle_capture (s_throttle_capture),
        .s_steer_start      (s_steer_start),
        .s_steer_end        (s_steer_end),
        .s_remote_byte      (s_remote_byte),
        .m_left_compare     (m_left_compare),
        .m_right_compare    (m_right_compare),
        .m_servo_compare    (m_servo_compare),
        .m_battery_byte     (m_battery_byte),
        .m_motors_written   (m_motors_written),
        .m_tilt_ok          (m_tilt_ok)
    );

endmodule
